### hw/rtl/lkv_pkg.sv
`default_nettype none

package lkv_pkg;

   // sizes
   localparam int MAX_ENTRIES = 64;
   localparam int KEY_W       = 64;
   localparam int VALUE_W     = 64;
   localparam int CFG_W       = 7;
   localparam int STATUS_W    = 3;

   localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
   localparam int GRP_SIZE   = 8;
   localparam int GRP_W      = $clog2(GRP_SIZE);
   localparam int NUM_GROUPS = (MAX_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int HIT_W      = GIDX_W + GRP_W;
   localparam int CAP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int CMP_W      = (HIT_W > CAP_W) ? HIT_W : CAP_W;

   localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(64);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EVICTED  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_HIT      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 3'd4;

   // one entry as it moves along the chain
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic             shift_all;
      logic             shift_upto;
      logic             evict;
      logic [HIT_W-1:0] hit_idx;
      logic [CAP_W-1:0] evict_from;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REDUCE,
      ST_UPDATE
   } ctrl_state_type;

endpackage

`default_nettype wire

### hw/rtl/lkv_cell.sv
`default_nettype none

module lkv_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [lkv_pkg::HIT_W-1:0]       cell_idx,
   input  lkv_pkg::cell_ctl_type           ctl,
   input  lkv_pkg::entry_type              prev_entry,
   input  logic [lkv_pkg::KEY_W-1:0]       lookup_key,
   output lkv_pkg::entry_type              fwd_entry,
   output logic                            match,
   output logic                            occupied,
   output logic [lkv_pkg::VALUE_W-1:0]     value
);
   import lkv_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;
   logic               take;
   logic               evicted;

   // take the neighbour's entry on a full shift, or up to the hit position
   assign take = ctl.shift_all || (ctl.shift_upto && (cell_idx <= ctl.hit_idx));

   // entries at or past the capacity edge are dropped as they move on
   assign evicted = ctl.evict && (CMP_W'(cell_idx) >= CMP_W'(ctl.evict_from));

   assign valid_in = take ? prev_entry.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         key_ff   <= prev_entry.key;
         value_ff <= prev_entry.value;
      end
   end

   // local key compare
   assign match    = valid_ff && (key_ff == lookup_key);
   assign occupied = valid_ff;
   assign value    = value_ff;

   assign fwd_entry.valid = valid_ff && !evicted;
   assign fwd_entry.key   = key_ff;
   assign fwd_entry.value = value_ff;

endmodule

`default_nettype wire

### hw/rtl/lkv_reduce.sv
`default_nettype none

module lkv_reduce (
   input  logic                                 clock,
   input  logic [lkv_pkg::MAX_ENTRIES-1:0]      match,
   input  logic [lkv_pkg::VALUE_W-1:0]          cell_value [lkv_pkg::MAX_ENTRIES],
   output logic                                 hit,
   output logic [lkv_pkg::HIT_W-1:0]            hit_idx,
   output logic [lkv_pkg::VALUE_W-1:0]          hit_value
);
   import lkv_pkg::*;

   logic               g1_hit_in [NUM_GROUPS];
   logic [GRP_W-1:0]   g1_idx_in [NUM_GROUPS];
   logic [VALUE_W-1:0] g1_val_in [NUM_GROUPS];
   logic               g1_hit_ff [NUM_GROUPS];
   logic [GRP_W-1:0]   g1_idx_ff [NUM_GROUPS];
   logic [VALUE_W-1:0] g1_val_ff [NUM_GROUPS];

   logic               hit_in;
   logic [HIT_W-1:0]   idx_in;
   logic [VALUE_W-1:0] val_in;
   logic               hit_ff;
   logic [HIT_W-1:0]   idx_ff;
   logic [VALUE_W-1:0] val_ff;

   // first level: or-combine each group of cells (keys are unique)
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         g1_hit_in[g] = 1'b0;
         g1_idx_in[g] = '0;
         g1_val_in[g] = '0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if ((g * GRP_SIZE + j) < MAX_ENTRIES) begin
               if (match[g * GRP_SIZE + j]) begin
                  g1_hit_in[g] = 1'b1;
                  g1_idx_in[g] = g1_idx_in[g] | GRP_W'(j);
                  g1_val_in[g] = g1_val_in[g] | cell_value[g * GRP_SIZE + j];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         g1_hit_ff[g] <= g1_hit_in[g];
         g1_idx_ff[g] <= g1_idx_in[g];
         g1_val_ff[g] <= g1_val_in[g];
      end
   end

   // second level: combine the groups
   always_comb begin
      hit_in = 1'b0;
      idx_in = '0;
      val_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         if (g1_hit_ff[g]) begin
            hit_in = 1'b1;
            idx_in = idx_in | {GIDX_W'(g), g1_idx_ff[g]};
            val_in = val_in | g1_val_ff[g];
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      idx_ff <= idx_in;
      val_ff <= val_in;
   end

   assign hit       = hit_ff;
   assign hit_idx   = idx_ff;
   assign hit_value = val_ff;

endmodule

`default_nettype wire

### hw/rtl/lru_key_value_store.sv
// a request word passes accept, compare with first reduce level, second reduce level and
// shift; its response word is registered at the shift, which waits while an earlier
// response word is valid and stalled; a new request is taken only after the shift
// a waiting response word does not block the next request until that one completes
// reset clears all entries, the entry count and the response valid, capacity returns to 64
`default_nettype none

module lru_key_value_store (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_operation,
   input  logic [lkv_pkg::KEY_W-1:0]         req_key,
   input  logic [lkv_pkg::VALUE_W-1:0]       req_value_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lkv_pkg::STATUS_W-1:0]      rsp_status,
   output logic [lkv_pkg::VALUE_W-1:0]       rsp_value_out,
   input  logic                              csr_write_en,
   input  logic [lkv_pkg::CFG_W-1:0]         csr_write_data
);
   import lkv_pkg::*;

   ctrl_state_type     state_ff;
   ctrl_state_type     state_in;

   logic [CFG_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   logic               op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [VALUE_W-1:0] value_ff;

   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0] status_in;
   logic [VALUE_W-1:0]  value_out_in;

   logic               req_accept;
   logic               upd_fire;
   logic [CAP_W-1:0]   cap_eff;
   logic               evict_needed;
   logic               do_insert;
   logic               do_move;

   cell_ctl_type       ctl;
   entry_type          head_entry;
   entry_type          fwd_entry [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] match;
   logic [MAX_ENTRIES-1:0] valid_bits;
   logic [VALUE_W-1:0] cell_value [MAX_ENTRIES];

   logic               hit;
   logic [HIT_W-1:0]   hit_idx;
   logic [VALUE_W-1:0] hit_value;

   // capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   // effective capacity: zero reads as one, saturates at the store size
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (CAP_W'(capacity_ff) > CAP_W'(MAX_ENTRIES)) begin
         cap_eff = CAP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = CAP_W'(capacity_ff);
      end
   end

   assign evict_needed = CAP_W'(count_ff) >= cap_eff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH:  state_in = ST_REDUCE;
         ST_REDUCE: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      upd_fire  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_UPDATE: upd_fire  = !rsp_valid_ff || !rsp_stall;
         default: begin
            req_stall = 1'b1;
            upd_fire  = 1'b0;
         end
      endcase
   end

   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_operation;
         key_ff   <= req_key;
         value_ff <= req_value_in;
      end
   end

   // chain control
   assign do_insert = upd_fire && (op_ff == OP_INSERT) && !hit;
   assign do_move   = upd_fire && (op_ff == OP_FIND) && hit;

   assign ctl.shift_all  = do_insert;
   assign ctl.shift_upto = do_move;
   assign ctl.evict      = (op_ff == OP_INSERT) && !hit && evict_needed;
   assign ctl.hit_idx    = hit_idx;
   assign ctl.evict_from = cap_eff - CAP_W'(1);

   // new most-recent entry entering the head of the chain
   assign head_entry.valid = 1'b1;
   assign head_entry.key   = key_ff;
   assign head_entry.value = (op_ff == OP_INSERT) ? value_ff : hit_value;

   // row of cells ordered by recency, cell 0 most recent
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type prev_entry;
      if (i == 0) begin : g_head
         assign prev_entry = head_entry;
      end else begin : g_link
         assign prev_entry = fwd_entry[i-1];
      end
      lkv_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (HIT_W'(i)),
         .ctl        (ctl),
         .prev_entry (prev_entry),
         .lookup_key (key_ff),
         .fwd_entry  (fwd_entry[i]),
         .match      (match[i]),
         .occupied   (valid_bits[i]),
         .value      (cell_value[i])
      );
   end

   lkv_reduce u_reduce (
      .clock      (clock),
      .match      (match),
      .cell_value (cell_value),
      .hit        (hit),
      .hit_idx    (hit_idx),
      .hit_value  (hit_value)
   );

   // entry count
   always_comb begin
      count_in = count_ff;
      if (do_insert) begin
         if (evict_needed) begin
            count_in = CNT_W'(cap_eff);
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response word
   always_comb begin
      value_out_in = '0;
      if (op_ff == OP_FIND) begin
         if (hit) begin
            status_in    = STATUS_HIT;
            value_out_in = hit_value;
         end else begin
            status_in = STATUS_MISS;
         end
      end else if (hit) begin
         status_in = STATUS_PRESENT;
      end else if (evict_needed) begin
         status_in = STATUS_EVICTED;
      end else begin
         status_in = STATUS_INSERTED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= value_out_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

`ifndef SYNTHESIS
   // the entry count tracks the number of occupied cells
   assert property (@(posedge clock) disable iff (reset)
      CNT_W'($countones(valid_bits)) == count_ff)
      else $error("entry count does not match occupied cells");

   // after an insert or a hit, the request key sits in the head cell
   assert property (@(posedge clock) disable iff (reset)
      (do_insert || do_move) |=> (valid_bits[0] && (fwd_entry[0].key == $past(key_ff))))
      else $error("head cell does not hold the last used key");

   // a response word only appears out of the update step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upd_fire))
      else $error("response word raised outside the update step");
`endif

endmodule

`default_nettype wire

### dv/lru_key_value_store_chk.sv
`default_nettype none

module lru_key_value_store_chk (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_operation,
   input  logic [lkv_pkg::KEY_W-1:0]     req_key,
   input  logic [lkv_pkg::VALUE_W-1:0]   req_value_in,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [lkv_pkg::STATUS_W-1:0]  rsp_status,
   input  logic [lkv_pkg::VALUE_W-1:0]   rsp_value_out,
   input  logic                          csr_write_en,
   input  logic [lkv_pkg::CFG_W-1:0]     csr_write_data,
   output int                            fail_count,
   output int                            words_waiting,
   output int                            words_checked,
   output int                            hit_count,
   output int                            evict_count,
   output int                            present_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import lkv_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
   } reply_type;

   // mirror of the store: slot contents, age order (0 is most recent) and fill level
   logic               slot_live  [MAX_ENTRIES];
   logic [KEY_W-1:0]   slot_key   [MAX_ENTRIES];
   logic [VALUE_W-1:0] slot_value [MAX_ENTRIES];
   int                 slot_age   [MAX_ENTRIES];
   int                 live_total;
   logic [CFG_W-1:0]   capacity_q;
   reply_type          replies_due [$];

   // capacity as the store applies it: zero acts as one, large values clip
   function automatic int usable_capacity();
      if (capacity_q == '0) return 1;
      if (int'(capacity_q) > MAX_ENTRIES) return MAX_ENTRIES;
      return int'(capacity_q);
   endfunction

   // apply one request word to the mirror and return the reply it should give
   function automatic reply_type lookup_and_update(input logic op,
                                                   input logic [KEY_W-1:0] k,
                                                   input logic [VALUE_W-1:0] v);
      reply_type r;
      int        found;
      int        cap;
      int        free_slot;
      int        age;
      r.status  = STATUS_MISS;
      r.value   = '0;
      found     = -1;
      free_slot = -1;
      for (int i = 0; i < MAX_ENTRIES; i++)
         if (slot_live[i] && slot_key[i] == k) found = i;

      if (op == OP_FIND) begin
         // a hit moves the entry to the front, younger entries age by one
         if (found >= 0) begin
            age = slot_age[found];
            for (int i = 0; i < MAX_ENTRIES; i++)
               if (slot_live[i] && slot_age[i] < age) slot_age[i]++;
            slot_age[found] = 0;
            r.status = STATUS_HIT;
            r.value  = slot_value[found];
         end
      end else if (found >= 0) begin
         r.status = STATUS_PRESENT;
      end else begin
         cap = usable_capacity();
         r.status = STATUS_INSERTED;
         // full (or over a lowered capacity): drop every entry too old to keep
         if (live_total >= cap) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (slot_live[i] && slot_age[i] >= cap - 1) begin
                  slot_live[i] = 1'b0;
                  live_total--;
               end
            end
            r.status = STATUS_EVICTED;
         end
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_live[i]) slot_age[i]++;
            else if (free_slot < 0) free_slot = i;
         end
         if (free_slot >= 0) begin
            slot_live[free_slot]  = 1'b1;
            slot_key[free_slot]   = k;
            slot_value[free_slot] = v;
            slot_age[free_slot]   = 0;
            live_total++;
         end
      end
      return r;
   endfunction

   // watch both channels and the register port on every rising edge
   always @(posedge clock) begin : watch
      reply_type want;
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
         end
         live_total = 0;
         capacity_q = CAP_RESET;
         replies_due.delete();
         fail_count    = 0;
         words_checked = 0;
         hit_count     = 0;
         evict_count   = 0;
         present_count = 0;
      end else begin
         // compare a delivered response word with the oldest reply due
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response word with nothing due: status %0d value_out %h",
                           $time, rsp_status, rsp_value_out);
            end else begin
               want = replies_due.pop_front();
               if (want.status == STATUS_HIT) hit_count++;
               if (want.status == STATUS_EVICTED) evict_count++;
               if (want.status == STATUS_PRESENT) present_count++;
               if (rsp_status !== want.status || rsp_value_out !== want.value) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: status exp %0d got %0d, value_out exp %h got %h",
                              $time, want.status, rsp_status, want.value, rsp_value_out);
               end
            end
         end

         if (csr_write_en) capacity_q = csr_write_data;

         if (req_valid && !req_stall)
            replies_due.push_back(lookup_and_update(req_operation, req_key, req_value_in));
      end
      words_waiting = replies_due.size();
   end

endmodule

`default_nettype wire

### dv/lru_key_value_store_tb.sv
`default_nettype none

module lru_key_value_store_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkv_pkg::*;

   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 180;
   localparam int HOLD_CYCLES = 150;
   localparam int SETTLE      = 8;
   localparam int CYCLE_LIMIT = 400000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_operation;
   logic [KEY_W-1:0]    req_key;
   logic [VALUE_W-1:0]  req_value_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_value_out;
   logic                csr_write_en;
   logic [CFG_W-1:0]    csr_write_data;

   int fail_count;
   int words_waiting;
   int words_checked;
   int hit_count;
   int evict_count;
   int present_count;

   int               words_sent;
   int               cycle_count;
   logic             hold_ask;
   logic             tail_quiet;
   logic [KEY_W-1:0] key_pool [100];
   int               pool_n;

   lru_key_value_store dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   lru_key_value_store_chk chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_key        (req_key),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_value_out  (rsp_value_out),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .words_waiting  (words_waiting),
      .words_checked  (words_checked),
      .hit_count      (hit_count),
      .evict_count    (evict_count),
      .present_count  (present_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_key_value_store_tb: done, errors");
         $finish;
      end
   end

   // response side: random stall bursts, calm stretches, one long hold on request
   initial begin : rsp_side
      int burst;
      int calm;
      burst = 0;
      calm  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_ask  = 1'b0;
            rsp_stall = 1'b0;
         end else if (tail_quiet) begin
            rsp_stall = 1'b0;
         end else if (burst > 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else if (calm > 0) begin
            rsp_stall = 1'b0;
            calm--;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            burst = $urandom_range(1, 11) - 1;
         end else begin
            rsp_stall = 1'b0;
            calm = $urandom_range(0, 30);
         end
      end
   end

   // offer one request word, with an occasional gap first, and wait until taken
   task automatic send_word(input logic op, input logic [KEY_W-1:0] k,
                            input logic [VALUE_W-1:0] v);
      int gap;
      if (!tail_quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         gap = $urandom_range(1, 11);
         repeat (gap) @(negedge clock);
      end
      req_operation = op;
      req_key       = k;
      req_value_in  = v;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      words_sent++;
   endtask

   // stop offering until every reply has come back, then let the block settle
   task automatic drain_words();
      req_valid = 1'b0;
      while (words_waiting != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // stimulus
   initial begin : stim
      logic [CFG_W-1:0]   cap_plan [PHASES];
      logic [CFG_W-1:0]   cap_now;
      int                 eff;
      logic               op;
      logic [KEY_W-1:0]   k;
      logic [VALUE_W-1:0] v;
      int                 pick;

      cap_plan = '{7'd127, 7'd5, 7'd0, 7'd1, 7'd64, 7'd2, 7'd100, 7'd33, 7'd8, 7'd64};
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_operation  = OP_INSERT;
      req_key        = '0;
      req_value_in   = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      hold_ask       = 1'b0;
      tail_quiet     = 1'b0;
      words_sent     = 0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed words at the reset capacity: empty store, extreme keys and values,
      // hits, a duplicate insert that must leave the old value alone
      send_word(OP_FIND,   '0, '0);
      send_word(OP_INSERT, '0, '1);
      send_word(OP_INSERT, '1, '0);
      send_word(OP_FIND,   '0, '0);
      send_word(OP_FIND,   '1, '1);
      send_word(OP_INSERT, '0, 64'd5);
      send_word(OP_FIND,   '0, '0);
      send_word(OP_FIND,   64'h8000_0000_0000_0000, '0);
      send_word(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_word(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      send_word(OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA, '1);
      send_word(OP_INSERT, 64'h8000_0000_0000_0001, 64'd1);
      drain_words();

      // random phases, one capacity setting each; lowering the capacity below
      // the fill level makes the first new insert evict several entries at once
      for (int ph = 0; ph < PHASES; ph++) begin
         cap_now = (ph == PHASES - 1) ? CFG_W'($urandom_range(1, 64)) : cap_plan[ph];
         csr_write_data = cap_now;
         csr_write_en   = 1'b1;
         @(negedge clock);
         csr_write_en   = 1'b0;

         // key pool a little larger than the store so hits and evictions both happen
         eff = (cap_now == '0) ? 1 : ((int'(cap_now) > MAX_ENTRIES) ? MAX_ENTRIES
                                                                    : int'(cap_now));
         pool_n = eff + eff / 2 + 2;
         key_pool[0] = '0;
         key_pool[1] = '1;
         for (int i = 2; i < pool_n; i++) key_pool[i] = {$urandom, $urandom};

         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ((ph == 1 || ph == 5) && n == 50) hold_ask = 1'b1;
            if (ph == 3 && n == 90) drain_words();
            if (ph == PHASES - 1 && n == 30) tail_quiet = 1'b1;
            op = ($urandom_range(0, 1) == 1) ? OP_FIND : OP_INSERT;
            if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, pool_n - 1)];
            else k = {$urandom, $urandom};
            pick = $urandom_range(0, 19);
            if (pick == 0) v = '0;
            else if (pick == 1) v = '1;
            else v = {$urandom, $urandom};
            send_word(op, k, v);
         end
         drain_words();
      end

      $display("covered %0d request words over %0d capacity settings incl. 0, 1 and 127",
               words_sent, PHASES + 1);
      $display("checked %0d response words: %0d find hits, %0d evicting inserts, %0d duplicates",
               words_checked, hit_count, evict_count, present_count);
      if (fail_count == 0 && words_waiting == 0) begin
         $display("lru_key_value_store_tb: done, clean");
      end else begin
         $display("lru_key_value_store_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
